@@ hw/rtl/svv_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package svv_pkg;

  typedef enum logic [2:0] {
    PH_MAJOR = 3'd0,
    PH_MINOR = 3'd1,
    PH_PATCH = 3'd2,
    PH_PRE   = 3'd3,
    PH_BUILD = 3'd4,
    PH_ERR   = 3'd5
  } phase_e;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } in_word_t;

  typedef struct packed {
    logic        valid_res;
    logic [63:0] major;
    logic [63:0] minor;
    logic [63:0] patch;
    logic        has_prerelease;
    logic [8:0]  prerelease_start;
    logic [8:0]  prerelease_size;
    logic        has_build;
    logic [8:0]  build_offset;
    logic [8:0]  build_size;
  } out_word_t;

  typedef struct packed {
    logic digits;
    logic leadz;
  } num_flags_t;

  typedef struct packed {
    logic nonempty;
    logic alldig;
    logic firstz;
    logic multi;
  } ident_flags_t;

  localparam ident_flags_t IdentReset = '{nonempty: 1'b0, alldig: 1'b1,
                                          firstz: 1'b0, multi: 1'b0};

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowZ  = 8'h7A;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpZ   = 8'h5A;

endpackage

`default_nettype wire

@@ hw/rtl/svv_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svv_core import svv_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      step_i,
  input  wire in_word_t  item_i,
  output out_word_t      res_o
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int WW = (PW > 9) ? PW : 9;
  localparam logic [PW-1:0] MaxPos = PW'(MAX_LEN);

  function automatic logic ident_ok(input ident_flags_t f, input logic strict);
    logic r;
    r = f.nonempty;
    if (strict && f.alldig && f.firstz && f.multi) begin
      r = 1'b0;
    end
    return r;
  endfunction

  function automatic logic [8:0] to9(input logic [PW-1:0] v);
    logic [WW-1:0] w;
    w = WW'(v);
    return w[8:0];
  endfunction

  phase_e       phase_q, phase_d;
  logic [63:0]  acc_q, acc_d;
  num_flags_t   nf_q, nf_d;
  logic [63:0]  major_q, major_d;
  logic [63:0]  minor_q, minor_d;
  logic [63:0]  patch_q, patch_d;
  logic [PW-1:0] pos_q, pos_d;
  ident_flags_t ident_q, ident_d;
  logic [PW-1:0] pre_ofs_q, pre_ofs_d;
  logic [PW-1:0] pre_len_q, pre_len_d;
  logic         pre_present_q, pre_present_d;
  logic [PW-1:0] bld_ofs_q, bld_ofs_d;

  logic [7:0]   c;
  logic         digit_ch;
  logic         is_ident;
  logic         strict;
  logic         clr_num;
  logic [3:0]   dval;
  logic [67:0]  times_ten;
  logic         ovf;
  logic         ok;
  logic         has_build;
  logic [63:0]  patch_fin;
  logic [PW-1:0] pre_len_fin;
  logic [PW-1:0] bld_size_fin;

  assign c        = item_i.char_code;
  assign digit_ch = (c >= ChZero) && (c <= ChNine);
  assign is_ident = digit_ch || ((c >= ChLowA) && (c <= ChLowZ)) ||
                    ((c >= ChUpA) && (c <= ChUpZ)) || (c == ChMinus);
  assign strict   = (phase_q == PH_PRE);
  assign dval     = 4'(c - ChZero);
  assign times_ten = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + 68'(dval);
  assign ovf      = |times_ten[67:64];

  always_comb begin
    phase_d       = phase_q;
    acc_d         = acc_q;
    nf_d          = nf_q;
    major_d       = major_q;
    minor_d       = minor_q;
    patch_d       = patch_q;
    pos_d         = pos_q;
    ident_d       = ident_q;
    pre_ofs_d     = pre_ofs_q;
    pre_len_d     = pre_len_q;
    pre_present_d = pre_present_q;
    bld_ofs_d     = bld_ofs_q;
    clr_num       = 1'b0;

    if (phase_q != PH_ERR) begin
      if (pos_q >= MaxPos) begin
        phase_d = PH_ERR;
      end else begin
        pos_d = pos_q + 1'b1;
        if (phase_q == PH_MAJOR || phase_q == PH_MINOR || phase_q == PH_PATCH) begin
          if (digit_ch) begin
            if (nf_q.leadz || ovf) begin
              phase_d = PH_ERR;
            end else begin
              acc_d = times_ten[63:0];
              if (!nf_q.digits && dval == 4'd0) begin
                nf_d.leadz = 1'b1;
              end
              nf_d.digits = 1'b1;
            end
          end else if (!nf_q.digits) begin
            phase_d = PH_ERR;
          end else if (c == ChDot && phase_q == PH_MAJOR) begin
            major_d = acc_q;
            phase_d = PH_MINOR;
            clr_num = 1'b1;
          end else if (c == ChDot && phase_q == PH_MINOR) begin
            minor_d = acc_q;
            phase_d = PH_PATCH;
            clr_num = 1'b1;
          end else if (c == ChMinus && phase_q == PH_PATCH) begin
            patch_d       = acc_q;
            pre_present_d = 1'b1;
            pre_ofs_d     = pos_q + 1'b1;
            phase_d       = PH_PRE;
            clr_num       = 1'b1;
          end else if (c == ChPlus && phase_q == PH_PATCH) begin
            patch_d   = acc_q;
            bld_ofs_d = pos_q + 1'b1;
            phase_d   = PH_BUILD;
            clr_num   = 1'b1;
          end else begin
            phase_d = PH_ERR;
          end
          if (clr_num) begin
            acc_d   = '0;
            nf_d    = '0;
            ident_d = IdentReset;
          end
        end else begin
          if (c == ChDot) begin
            if (!ident_ok(ident_q, strict)) begin
              phase_d = PH_ERR;
            end else begin
              ident_d = IdentReset;
            end
          end else if (c == ChPlus && strict) begin
            if (!ident_ok(ident_q, 1'b1)) begin
              phase_d = PH_ERR;
            end else begin
              pre_len_d = pos_q - pre_ofs_q;
              bld_ofs_d = pos_q + 1'b1;
              phase_d   = PH_BUILD;
              ident_d   = IdentReset;
            end
          end else if (is_ident) begin
            if (ident_q.nonempty) begin
              ident_d.multi = 1'b1;
            end else begin
              ident_d.nonempty = 1'b1;
              if (c == ChZero) begin
                ident_d.firstz = 1'b1;
              end
            end
            if (!digit_ch) begin
              ident_d.alldig = 1'b0;
            end
          end else begin
            phase_d = PH_ERR;
          end
        end
      end
    end
  end

  always_comb begin
    ok           = 1'b0;
    has_build    = 1'b0;
    patch_fin    = patch_d;
    pre_len_fin  = pre_len_d;
    bld_size_fin = '0;
    case (phase_d)
      PH_PATCH: begin
        ok        = nf_d.digits;
        patch_fin = acc_d;
      end
      PH_PRE: begin
        ok          = ident_ok(ident_d, 1'b1);
        pre_len_fin = pos_d - pre_ofs_d;
      end
      PH_BUILD: begin
        ok           = ident_ok(ident_d, 1'b0);
        has_build    = 1'b1;
        bld_size_fin = pos_d - bld_ofs_d;
      end
      default: begin
        ok = 1'b0;
      end
    endcase

    res_o = '0;
    if (ok) begin
      res_o.valid_res = 1'b1;
      res_o.major     = major_d;
      res_o.minor     = minor_d;
      res_o.patch     = patch_fin;
      if (pre_present_d) begin
        res_o.has_prerelease   = 1'b1;
        res_o.prerelease_start = to9(pre_ofs_d);
        res_o.prerelease_size  = to9(pre_len_fin);
      end
      if (has_build) begin
        res_o.has_build    = 1'b1;
        res_o.build_offset = to9(bld_ofs_d);
        res_o.build_size   = to9(bld_size_fin);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_MAJOR;
      acc_q         <= '0;
      nf_q          <= '0;
      major_q       <= '0;
      minor_q       <= '0;
      patch_q       <= '0;
      pos_q         <= '0;
      ident_q       <= IdentReset;
      pre_ofs_q     <= '0;
      pre_len_q     <= '0;
      pre_present_q <= 1'b0;
      bld_ofs_q     <= '0;
    end else if (step_i) begin
      if (item_i.last_char) begin
        phase_q       <= PH_MAJOR;
        acc_q         <= '0;
        nf_q          <= '0;
        major_q       <= '0;
        minor_q       <= '0;
        patch_q       <= '0;
        pos_q         <= '0;
        ident_q       <= IdentReset;
        pre_ofs_q     <= '0;
        pre_len_q     <= '0;
        pre_present_q <= 1'b0;
        bld_ofs_q     <= '0;
      end else begin
        phase_q       <= phase_d;
        acc_q         <= acc_d;
        nf_q          <= nf_d;
        major_q       <= major_d;
        minor_q       <= minor_d;
        patch_q       <= patch_d;
        pos_q         <= pos_d;
        ident_q       <= ident_d;
        pre_ofs_q     <= pre_ofs_d;
        pre_len_q     <= pre_len_d;
        pre_present_q <= pre_present_d;
        bld_ofs_q     <= bld_ofs_d;
      end
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/semver_string_validator.sv @@
// Strict SemVer 2.0.0 string checker. Feed the string one byte per input word,
// with last_char set on its final byte; exactly one result word follows that
// byte, and no other byte produces one. A byte is taken every cycle unless a
// final byte is waiting for the output register: it sits in the input
// register and is parsed by a single pass of logic (one multiply-by-ten, add
// and overflow check on the 64-bit accumulator) as it leaves, and a result
// is registered in the output register as its final byte leaves.
// The output register holds a result while out_stall_i is high; bytes that
// produce no result keep flowing meanwhile, and only a final byte waits for
// the output register to free up. Strings longer than MAX_LEN bytes are
// reported invalid, and an invalid result carries zeros in every field.
`timescale 1ns / 1ps
`default_nettype none

module semver_string_validator import svv_pkg::*; #(
  parameter int MAX_LEN = 256
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_word_t  in_word_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_word_t      out_word_o
);

  logic      in_valid_q;
  in_word_t  in_word_q;
  logic      out_valid_q;
  out_word_t out_word_q;
  out_word_t res;
  logic      out_free;
  logic      step;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && (!in_word_q.last_char || out_free);
  assign in_stall_o = in_valid_q && !step;

  svv_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_word_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_word_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && in_word_q.last_char;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && step && in_word_q.last_char) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

`default_nettype wire
